@@ rtl/rfid_ascii_hex_frame_checker_macros.svh @@
// Assertion macros for the RFID ASCII-hex frame checker.
`ifndef RFID_ASCII_HEX_FRAME_CHECKER_MACROS_SVH
`define RFID_ASCII_HEX_FRAME_CHECKER_MACROS_SVH

`ifndef SYNTHESIS
`define RAHFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rahfc: implication check failed");
`define RAHFC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rahfc: next-cycle check failed");
`else
`define RAHFC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RAHFC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/rahfc_pkg.sv @@
// Shared types and constants for the RFID ASCII-hex frame checker.
package rahfc_pkg;

    localparam int unsigned DataW   = 8;
    localparam int unsigned IdW     = 40;
    localparam int unsigned LimitW  = 4;
    localparam int unsigned PosW    = 4;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [DataW-1:0]  StartByteRst = 8'd2;
    localparam logic [DataW-1:0]  EndByteRst   = 8'd3;
    localparam logic [LimitW-1:0] ZeroLimitRst = 4'd6;

    localparam logic [DataW-1:0] AsciiZero  = 8'h30;
    localparam logic [DataW-1:0] AlphaGap   = 8'd7;
    localparam logic [DataW-1:0] DigitMax   = 8'd9;
    localparam logic [PosW-1:0]  PosStart   = 4'd0;
    localparam logic [PosW-1:0]  PosIdLast  = 4'd10;
    localparam logic [PosW-1:0]  PosEnd     = 4'd13;
    localparam logic [PosW-1:0]  PosMax     = 4'd15;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_START_BYTE = 2'd0,
        CFG_END_BYTE   = 2'd1,
        CFG_ZERO_LIMIT = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_ZEROS     = 3'd2,
        ST_BAD_FRAME = 3'd3,
        ST_BAD_SUM   = 3'd4
    } t_frame_status;

    typedef struct packed {
        logic [DataW-1:0] rx_byte;
        logic             last_byte;
    } t_rx_req;

    typedef struct packed {
        logic [IdW-1:0] tag_id;
        t_frame_status  frame_status;
        logic           tag_valid;
    } t_tag_res;

    // full 8-bit value: non-hex characters wrap and carry into the pair sum
    function automatic logic [DataW-1:0] to_nibble(input logic [DataW-1:0] c);
        logic [DataW-1:0] n;
        n = c - AsciiZero;
        if (n > DigitMax) begin
            n = n - AlphaGap;
        end
        return n;
    endfunction

endpackage

@@ rtl/rfid_ascii_hex_frame_checker.sv @@
// Top level: RFID ASCII-hex frame checker with XOR checksum.
//  channel | direction | handshake                 | payload
//  in      | request   | i_in_valid / o_in_stall   | i_in_data  (rx_byte, last_byte)
//  out     | result    | o_out_valid / i_out_stall | o_out_data (tag_id, status, valid)
//  cfg     | write     | i_cfg_we                  | i_cfg_idx, i_cfg_wdata
// One byte per cycle while no final byte waits on the output.
// Byte register, then the chunk update and checks, then the result register.
// A non-final byte never waits on the output; a final byte waits while the
// result register is held by i_out_stall.
// Synchronous active-low reset clears control and chunk state; config resets to 2, 3, 6.
`include "rfid_ascii_hex_frame_checker_macros.svh"
module rfid_ascii_hex_frame_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  rahfc_pkg::t_rx_req            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output rahfc_pkg::t_tag_res           o_out_data,
    input  logic                          i_cfg_we,
    input  logic [rahfc_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [rahfc_pkg::DataW-1:0]   i_cfg_wdata
);
    import rahfc_pkg::*;

    logic [DataW-1:0]  r_start_byte;
    logic [DataW-1:0]  r_end_byte;
    logic [LimitW-1:0] r_zero_limit;

    logic     r_s1_valid, n_s1_valid;
    t_rx_req  r_s1;
    logic     s1_move;
    logic     in_take;
    logic     out_free;
    t_tag_res chk_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= StartByteRst;
            r_end_byte   <= EndByteRst;
            r_zero_limit <= ZeroLimitRst;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_START_BYTE: r_start_byte <= i_cfg_wdata;
                CFG_END_BYTE:   r_end_byte   <= i_cfg_wdata;
                CFG_ZERO_LIMIT: r_zero_limit <= i_cfg_wdata[LimitW-1:0];
                default: ;
            endcase
        end
    end

    assign s1_move    = r_s1_valid && (!r_s1.last_byte || out_free);
    assign o_in_stall = r_s1_valid && !s1_move;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_take) begin
            n_s1_valid = 1'b1;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1 <= i_in_data;
        end
    end

    rahfc_chunk u_chunk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (s1_move),
        .i_req        (r_s1),
        .i_start_byte (r_start_byte),
        .i_end_byte   (r_end_byte),
        .i_zero_limit (r_zero_limit),
        .o_res        (chk_res)
    );

    rahfc_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_move && r_s1.last_byte),
        .i_res   (chk_res),
        .i_stall (i_out_stall),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_res   (o_out_data)
    );

    `RAHFC_ASSERT_IMP(a_valid_matches_ok, i_clk, i_rst_n, o_out_valid, o_out_data.tag_valid == (o_out_data.frame_status == ST_OK))
    `RAHFC_ASSERT_IMP(a_id_zero_on_fail, i_clk, i_rst_n, o_out_valid && !o_out_data.tag_valid, o_out_data.tag_id == '0)
    `RAHFC_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall, r_s1_valid && r_s1.last_byte && o_out_valid && i_out_stall)
    `RAHFC_ASSERT_NXT(a_held_byte_kept, i_clk, i_rst_n, o_in_stall, r_s1_valid)

endmodule

@@ rtl/rahfc_chunk.sv @@
// Per-chunk running state and frame checks.
module rahfc_chunk (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  rahfc_pkg::t_rx_req           i_req,
    input  logic [rahfc_pkg::DataW-1:0]  i_start_byte,
    input  logic [rahfc_pkg::DataW-1:0]  i_end_byte,
    input  logic [rahfc_pkg::LimitW-1:0] i_zero_limit,
    output rahfc_pkg::t_tag_res          o_res
);
    import rahfc_pkg::*;

    logic [PosW-1:0]  r_pos,   n_pos;
    logic [3:0]       r_zeros, n_zeros;
    logic             r_start, n_start;
    logic             r_end,   n_end;
    logic [3:0]       r_hold,  n_hold;
    logic [IdW-1:0]   r_id,    n_id;
    logic [DataW-1:0] r_xor,   n_xor;
    logic [DataW-1:0] r_sum,   n_sum;

    logic [DataW-1:0] nib;
    logic [DataW-1:0] pair;
    logic             in_frame;

    assign nib      = to_nibble(i_req.rx_byte);
    assign pair     = {r_hold, 4'b0000} + nib;
    assign in_frame = (r_pos <= PosEnd);

    always_comb begin
        n_zeros = r_zeros;
        n_start = r_start;
        n_end   = r_end;
        n_hold  = r_hold;
        n_id    = r_id;
        n_xor   = r_xor;
        n_sum   = r_sum;
        if (in_frame) begin
            if (r_pos == PosStart) begin
                n_start = (i_req.rx_byte == i_start_byte);
            end else if (r_pos == PosEnd) begin
                n_end = (i_req.rx_byte == i_end_byte);
            end else if (r_pos[0]) begin
                n_hold = nib[3:0];
            end else if (r_pos <= PosIdLast) begin
                n_id  = {r_id[IdW-DataW-1:0], pair};
                n_xor = r_xor ^ pair;
            end else begin
                n_sum = pair;
            end
            if (r_pos != PosStart && r_pos <= PosIdLast && i_req.rx_byte == AsciiZero) begin
                n_zeros = r_zeros + 4'd1;
            end
        end
        n_pos = (r_pos == PosMax) ? r_pos : r_pos + 4'd1;
    end

    always_comb begin
        o_res.tag_id = '0;
        if (r_pos < PosEnd) begin
            o_res.frame_status = ST_SHORT;
        end else if (n_zeros >= i_zero_limit) begin
            o_res.frame_status = ST_ZEROS;
        end else if (!n_start || !n_end) begin
            o_res.frame_status = ST_BAD_FRAME;
        end else if (n_xor != n_sum) begin
            o_res.frame_status = ST_BAD_SUM;
        end else begin
            o_res.frame_status = ST_OK;
            o_res.tag_id       = n_id;
        end
        o_res.tag_valid = (o_res.frame_status == ST_OK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_req.last_byte)) begin
            r_pos   <= '0;
            r_zeros <= '0;
            r_start <= 1'b0;
            r_end   <= 1'b0;
            r_hold  <= '0;
            r_id    <= '0;
            r_xor   <= '0;
            r_sum   <= '0;
        end else if (i_take) begin
            r_pos   <= n_pos;
            r_zeros <= n_zeros;
            r_start <= n_start;
            r_end   <= n_end;
            r_hold  <= n_hold;
            r_id    <= n_id;
            r_xor   <= n_xor;
            r_sum   <= n_sum;
        end
    end

endmodule

@@ rtl/rahfc_out_stage.sv @@
// Result register with downstream stall.
module rahfc_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  rahfc_pkg::t_tag_res i_res,
    input  logic                i_stall,
    output logic                o_free,
    output logic                o_valid,
    output rahfc_pkg::t_tag_res o_res
);
    import rahfc_pkg::*;

    logic     r_valid, n_valid;
    t_tag_res r_res;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
